FILE: design/hrhp_pkg.sv
// Shared types, codes and character helpers for the HTTP reply header parser.
// No dependencies; used by hrhp_core and http_reply_header_parser.
`timescale 1ns / 1ps
`default_nettype none
package hrhp_pkg;

    localparam int LINE_BUFFER = 256;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_CLOSE   = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [1:0] OUT_LOC_BYTE = 2'd0;
    localparam logic [1:0] OUT_LOC_END  = 2'd1;
    localparam logic [1:0] OUT_DONE     = 2'd2;
    localparam logic [1:0] OUT_ERROR    = 2'd3;

    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_REDIRECT  = 3'd1;
    localparam logic [2:0] VERDICT_NO_TARGET = 3'd2;
    localparam logic [2:0] VERDICT_OTHER     = 3'd3;
    localparam logic [2:0] VERDICT_CHUNKED   = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT   = 3'd1;
    localparam logic [2:0] ERR_CLOSED    = 3'd2;
    localparam logic [2:0] ERR_NOT_HTTP  = 3'd3;
    localparam logic [2:0] ERR_MALFORMED = 3'd4;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd5;

    localparam logic [1:0] REG_LINE_LIMIT  = 2'd0;
    localparam logic [1:0] REG_TOTAL_LIMIT = 2'd1;
    localparam logic [1:0] REG_TIMEOUT     = 2'd2;

    localparam logic [7:0]  LINE_LIMIT_RESET  = 8'd255;
    localparam logic [13:0] TOTAL_LIMIT_RESET = 14'd8192;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd20000;

    localparam logic [2:0] NUM_FIND   = 3'd0;
    localparam logic [2:0] NUM_WS     = 3'd1;
    localparam logic [2:0] NUM_SIGN   = 3'd2;
    localparam logic [2:0] NUM_DIGITS = 3'd3;
    localparam logic [2:0] NUM_END    = 3'd4;

    localparam logic [2:0] CLS_UNDECIDED = 3'd0;
    localparam logic [2:0] CLS_NAME_LEN  = 3'd1;
    localparam logic [2:0] CLS_NAME_ENC  = 3'd2;
    localparam logic [2:0] CLS_NAME_LOC  = 3'd3;
    localparam logic [2:0] CLS_OTHER     = 3'd4;
    localparam logic [2:0] CLS_LENGTH    = 3'd5;
    localparam logic [2:0] CLS_ENCODING  = 3'd6;
    localparam logic [2:0] CLS_LOCATION  = 3'd7;

    localparam logic [32:0] ACC_CAP = 33'h1_0000_0000;

    localparam logic [8*5-1:0]  STATUS_PREFIX = "HTTP/";
    localparam logic [8*15-1:0] NAME_LENGTH   = "content-length:";
    localparam logic [8*18-1:0] NAME_ENCODING = "transfer-encoding:";
    localparam logic [8*9-1:0]  NAME_LOCATION = "location:";
    localparam logic [8*7-1:0]  CHUNK_WORD    = "chunked";

    typedef struct packed {
        logic [7:0]  line_limit;
        logic [13:0] total_limit;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         out_kind;
        logic [7:0]         location_byte;
        logic signed [15:0] status_code;
        logic [31:0]        content_length;
        logic               has_length;
        logic               chunked_seen;
        logic               has_location;
        logic [2:0]         verdict;
        logic [2:0]         error_code;
    } res_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        negative;
        logic [32:0] acc;
    } num_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z")
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic [7:0] prefix_char(input logic [7:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos < 8'd5)
        begin
            ch = STATUS_PREFIX[8*(4-pos[2:0]) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] name_char(input logic [2:0] cls, input logic [7:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (cls == CLS_NAME_LEN && pos < 8'd15)
        begin
            ch = NAME_LENGTH[8*(14-pos[4:0]) +: 8];
        end
        else if (cls == CLS_NAME_ENC && pos < 8'd18)
        begin
            ch = NAME_ENCODING[8*(17-pos[4:0]) +: 8];
        end
        else if (cls == CLS_NAME_LOC && pos < 8'd9)
        begin
            ch = NAME_LOCATION[8*(8-pos[3:0]) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] name_last(input logic [2:0] cls);
        logic [7:0] n;
        unique case (cls)
            CLS_NAME_LEN: n = 8'd14;
            CLS_NAME_ENC: n = 8'd17;
            default:      n = 8'd8;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] chunk_char(input logic [2:0] idx);
        return CHUNK_WORD[8*(6-idx) +: 8];
    endfunction

    function automatic num_t num_step(input num_t s, input logic [7:0] c);
        num_t        r;
        logic        go;
        logic [36:0] prod;
        r  = s;
        go = 1'b1;
        if (r.phase == NUM_WS)
        begin
            if (is_ws(c))
            begin
                go = 1'b0;
            end
            else if (c == "+" || c == "-")
            begin
                r.negative = (c == "-");
                r.phase    = NUM_SIGN;
                go         = 1'b0;
            end
            else
            begin
                r.phase = NUM_SIGN;
            end
        end
        if (go && (r.phase == NUM_SIGN || r.phase == NUM_DIGITS))
        begin
            if (c >= "0" && c <= "9")
            begin
                prod = {1'b0, r.acc, 3'b000} + {3'b000, r.acc, 1'b0}
                     + {33'd0, c[3:0] - 4'd0};
                r.acc   = (prod > {4'd0, ACC_CAP}) ? ACC_CAP : prod[32:0];
                r.phase = NUM_DIGITS;
            end
            else
            begin
                r.phase = NUM_END;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/http_reply_header_parser.sv
// Top level: configuration registers, parser core and registered result output.
// Depends on hrhp_pkg and hrhp_core.
`timescale 1ns / 1ps
`default_nettype none
// Takes one event per clock (data byte, close, tick or restart) and returns at most one
// result per event, in the cycle after the event transfer. The parser state updates in the
// cycle of the transfer, so an event may follow in every cycle; the single result register
// stalls input only while a result waits and result_ready is low. Configuration writes
// are always taken and should be made while the parser is idle.
module http_reply_header_parser
    import hrhp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [1:0]         kind,
    input  wire logic [7:0]         data_byte,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [1:0]              out_kind,
    output logic [7:0]              location_byte,
    output logic signed [15:0]      status_code,
    output logic [31:0]             content_length,
    output logic                    has_length,
    output logic                    chunked_seen,
    output logic                    has_location,
    output logic [2:0]              verdict,
    output logic [2:0]              error_code
);

    cfg_t cfg_reg;
    res_t core_res;
    res_t res_reg;
    logic result_valid_reg, result_valid_next;
    logic step;

    assign item_ready = !result_valid_reg || result_ready;
    assign cfg_ready  = 1'b1;
    assign step       = item_valid && item_ready;

    hrhp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .kind      (kind),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_limit    <= LINE_LIMIT_RESET;
            cfg_reg.total_limit   <= TOTAL_LIMIT_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINE_LIMIT:  cfg_reg.line_limit    <= cfg_data[7:0];
                REG_TOTAL_LIMIT: cfg_reg.total_limit   <= cfg_data[13:0];
                REG_TIMEOUT:     cfg_reg.timeout_ticks <= cfg_data;
                default:         cfg_reg.line_limit    <= cfg_reg.line_limit;
            endcase
        end
    end

    assign result_valid_next = (step && core_res.valid) || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && core_res.valid)
        begin
            res_reg <= core_res;
        end
    end

    assign result_valid   = result_valid_reg;
    assign out_kind       = res_reg.out_kind;
    assign location_byte  = res_reg.location_byte;
    assign status_code    = res_reg.status_code;
    assign content_length = res_reg.content_length;
    assign has_length     = res_reg.has_length;
    assign chunked_seen   = res_reg.chunked_seen;
    assign has_location   = res_reg.has_location;
    assign verdict        = res_reg.verdict;
    assign error_code     = res_reg.error_code;

endmodule
`default_nettype wire

FILE: design/hrhp_core.sv
// Parser state and per-event update logic: one event per cycle, at most one result.
// Depends on hrhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_core
    import hrhp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] data_byte,
    input  wire cfg_t       cfg,
    output res_t            res
);

    localparam logic [1:0] PH_STATUS  = 2'd0;
    localparam logic [1:0] PH_HEADERS = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  line_length_reg, line_length_next;
    logic [13:0] header_total_reg, header_total_next;
    logic [2:0]  line_class_reg, line_class_next;
    logic [2:0]  number_phase_reg, number_phase_next;
    logic        number_negative_reg, number_negative_next;
    logic [15:0] status_value_reg, status_value_next;
    logic [32:0] acc_reg, acc_next;
    logic [31:0] length_value_reg, length_value_next;
    logic        length_seen_reg, length_seen_next;
    logic [2:0]  chunk_match_reg, chunk_match_next;
    logic        chunk_flag_reg, chunk_flag_next;
    logic        location_nonempty_reg, location_nonempty_next;
    logic        location_flag_reg, location_flag_next;
    logic        line_cut_reg, line_cut_next;
    logic [15:0] tick_count_reg, tick_count_next;

    logic [2:0]  st_err;
    logic [15:0] st_value;
    logic [14:0] total;
    logic        cm_err;
    logic [31:0] cm_length;
    logic [16:0] tick_sum;
    logic [7:0]  pos;
    logic [7:0]  lc;
    logic        restart;
    logic        line_start;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [7:0]  emit_byte;
    logic [2:0]  emit_verdict;
    logic [2:0]  emit_err;
    logic        chunk_ok;
    num_t        num_cur;
    num_t        num_new;

    always_comb
    begin
        st_err = ERR_NONE;
        if (line_length_reg < 8'd5 || line_class_reg == CLS_OTHER)
        begin
            st_err = ERR_NOT_HTTP;
        end
        else if (number_phase_reg == NUM_FIND)
        begin
            st_err = ERR_MALFORMED;
        end
        if (number_negative_reg)
        begin
            st_value = (acc_reg > 33'd32768) ? 16'h8000 : (16'd0 - acc_reg[15:0]);
        end
        else
        begin
            st_value = (acc_reg > 33'd32767) ? 16'h7FFF : acc_reg[15:0];
        end
        total  = {1'b0, header_total_reg} + {7'd0, line_length_reg};
        cm_err = total > {1'b0, cfg.total_limit};
        if (acc_reg[32])
        begin
            cm_length = 32'hFFFF_FFFF;
        end
        else if (number_negative_reg)
        begin
            cm_length = 32'd0 - acc_reg[31:0];
        end
        else
        begin
            cm_length = acc_reg[31:0];
        end
        tick_sum = {1'b0, tick_count_reg} + 17'd1;
        pos      = line_length_reg;
        lc       = to_lower(data_byte);
        num_cur  = '{phase: number_phase_reg, negative: number_negative_reg, acc: acc_reg};
        num_new  = num_step(num_cur, data_byte);
        chunk_ok = (chunk_match_reg == 3'd0) ? (data_byte == "c" || data_byte == "C")
                                              : (data_byte == chunk_char(chunk_match_reg));
    end

    always_comb
    begin
        phase_next             = phase_reg;
        line_length_next       = line_length_reg;
        header_total_next      = header_total_reg;
        line_class_next        = line_class_reg;
        number_phase_next      = number_phase_reg;
        number_negative_next   = number_negative_reg;
        status_value_next      = status_value_reg;
        acc_next               = acc_reg;
        length_value_next      = length_value_reg;
        length_seen_next       = length_seen_reg;
        chunk_match_next       = chunk_match_reg;
        chunk_flag_next        = chunk_flag_reg;
        location_nonempty_next = location_nonempty_reg;
        location_flag_next     = location_flag_reg;
        line_cut_next          = line_cut_reg;
        tick_count_next        = tick_count_reg;
        restart      = 1'b0;
        line_start   = 1'b0;
        emit         = 1'b0;
        emit_kind    = OUT_LOC_BYTE;
        emit_byte    = 8'd0;
        emit_verdict = VERDICT_OK;
        emit_err     = ERR_NONE;

        if (step)
        begin
            if (kind == KIND_RESTART)
            begin
                restart = 1'b1;
            end
            else if (phase_reg == PH_STATUS || phase_reg == PH_HEADERS)
            begin
                unique case (kind)
                    KIND_TICK:
                    begin
                        if (tick_sum > {1'b0, cfg.timeout_ticks})
                        begin
                            emit     = 1'b1;
                            emit_err = ERR_TIMEOUT;
                        end
                        else
                        begin
                            tick_count_next = tick_sum[15:0];
                        end
                    end
                    KIND_CLOSE:
                    begin
                        emit     = 1'b1;
                        emit_err = ERR_CLOSED;
                        if (line_length_reg != 8'd0)
                        begin
                            if (phase_reg == PH_STATUS)
                            begin
                                if (st_err != ERR_NONE)
                                begin
                                    emit_err = st_err;
                                end
                                else
                                begin
                                    status_value_next = st_value;
                                end
                            end
                            else if (cm_err)
                            begin
                                emit_err = ERR_TOO_LARGE;
                            end
                            else
                            begin
                                header_total_next = total[13:0];
                                if (line_class_reg == CLS_LENGTH)
                                begin
                                    length_value_next = cm_length;
                                    length_seen_next  = 1'b1;
                                end
                                else if (line_class_reg == CLS_ENCODING)
                                begin
                                    chunk_flag_next = chunk_flag_reg | (chunk_match_reg == 3'd7);
                                end
                                else if (line_class_reg == CLS_LOCATION)
                                begin
                                    location_flag_next = location_nonempty_reg;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        if (data_byte == 8'h0D)
                        begin
                            emit = 1'b0;
                        end
                        else if (data_byte == 8'h0A)
                        begin
                            if (phase_reg == PH_STATUS)
                            begin
                                if (st_err != ERR_NONE)
                                begin
                                    emit     = 1'b1;
                                    emit_err = st_err;
                                end
                                else
                                begin
                                    status_value_next = st_value;
                                    phase_next        = PH_HEADERS;
                                    line_start        = 1'b1;
                                end
                            end
                            else if (line_length_reg == 8'd0)
                            begin
                                emit      = 1'b1;
                                emit_kind = OUT_DONE;
                                priority if (chunk_flag_reg)
                                begin
                                    emit_verdict = VERDICT_CHUNKED;
                                end
                                else if (status_value_reg == 16'd301
                                      || status_value_reg == 16'd302
                                      || status_value_reg == 16'd303
                                      || status_value_reg == 16'd307
                                      || status_value_reg == 16'd308)
                                begin
                                    emit_verdict = location_flag_reg ? VERDICT_REDIRECT
                                                                     : VERDICT_NO_TARGET;
                                end
                                else if (status_value_reg == 16'd200)
                                begin
                                    emit_verdict = VERDICT_OK;
                                end
                                else
                                begin
                                    emit_verdict = VERDICT_OTHER;
                                end
                            end
                            else if (cm_err)
                            begin
                                emit     = 1'b1;
                                emit_err = ERR_TOO_LARGE;
                            end
                            else
                            begin
                                header_total_next = total[13:0];
                                line_start        = 1'b1;
                                if (line_class_reg == CLS_LENGTH)
                                begin
                                    length_value_next = cm_length;
                                    length_seen_next  = 1'b1;
                                end
                                else if (line_class_reg == CLS_ENCODING)
                                begin
                                    chunk_flag_next = chunk_flag_reg | (chunk_match_reg == 3'd7);
                                end
                                else if (line_class_reg == CLS_LOCATION)
                                begin
                                    location_flag_next = location_nonempty_reg;
                                    emit      = 1'b1;
                                    emit_kind = OUT_LOC_END;
                                end
                            end
                        end
                        else if (line_length_reg < cfg.line_limit)
                        begin
                            line_length_next = line_length_reg + 8'd1;
                            if (!line_cut_reg)
                            begin
                                if (phase_reg == PH_STATUS)
                                begin
                                    if (pos < 8'd5 && data_byte != prefix_char(pos))
                                    begin
                                        line_class_next = CLS_OTHER;
                                    end
                                    if (data_byte == 8'h00)
                                    begin
                                        line_cut_next = 1'b1;
                                        if (number_phase_reg != NUM_FIND)
                                        begin
                                            number_phase_next = NUM_END;
                                        end
                                    end
                                    else if (number_phase_reg == NUM_FIND)
                                    begin
                                        if (data_byte == 8'h20)
                                        begin
                                            number_phase_next = NUM_WS;
                                        end
                                    end
                                    else
                                    begin
                                        number_phase_next    = num_new.phase;
                                        number_negative_next = num_new.negative;
                                        acc_next             = num_new.acc;
                                    end
                                end
                                else if (data_byte == 8'h00)
                                begin
                                    line_cut_next = 1'b1;
                                    if (line_class_reg < CLS_OTHER)
                                    begin
                                        line_class_next = CLS_OTHER;
                                    end
                                    if (line_class_reg == CLS_LENGTH)
                                    begin
                                        number_phase_next = NUM_END;
                                    end
                                end
                                else
                                begin
                                    unique case (line_class_reg)
                                        CLS_UNDECIDED:
                                        begin
                                            if (lc == "c")
                                            begin
                                                line_class_next = CLS_NAME_LEN;
                                            end
                                            else if (lc == "t")
                                            begin
                                                line_class_next = CLS_NAME_ENC;
                                            end
                                            else if (lc == "l")
                                            begin
                                                line_class_next = CLS_NAME_LOC;
                                            end
                                            else
                                            begin
                                                line_class_next = CLS_OTHER;
                                            end
                                        end
                                        CLS_NAME_LEN, CLS_NAME_ENC, CLS_NAME_LOC:
                                        begin
                                            if (lc != name_char(line_class_reg, pos))
                                            begin
                                                line_class_next = CLS_OTHER;
                                            end
                                            else if (pos == name_last(line_class_reg))
                                            begin
                                                line_class_next = line_class_reg + 3'd4;
                                            end
                                        end
                                        CLS_LENGTH:
                                        begin
                                            number_phase_next    = num_new.phase;
                                            number_negative_next = num_new.negative;
                                            acc_next             = num_new.acc;
                                        end
                                        CLS_ENCODING:
                                        begin
                                            if (chunk_match_reg < 3'd7)
                                            begin
                                                if (chunk_ok)
                                                begin
                                                    chunk_match_next = chunk_match_reg + 3'd1;
                                                end
                                                else
                                                begin
                                                    chunk_match_next =
                                                        (data_byte == "c" || data_byte == "C")
                                                        ? 3'd1 : 3'd0;
                                                end
                                            end
                                        end
                                        CLS_LOCATION:
                                        begin
                                            if (location_nonempty_reg
                                                || !(data_byte == 8'h20 || data_byte == 8'h09))
                                            begin
                                                location_nonempty_next = 1'b1;
                                                emit      = 1'b1;
                                                emit_kind = OUT_LOC_BYTE;
                                                emit_byte = data_byte;
                                            end
                                        end
                                        default:
                                        begin
                                            emit = 1'b0;
                                        end
                                    endcase
                                end
                            end
                        end
                    end
                endcase
                if (emit && (emit_kind == OUT_ERROR || emit_kind == OUT_DONE
                             || emit_err != ERR_NONE))
                begin
                    phase_next = PH_DONE;
                end
                if (emit_err != ERR_NONE)
                begin
                    emit_kind = OUT_ERROR;
                end
            end
        end

        if (restart)
        begin
            phase_next         = PH_STATUS;
            header_total_next  = 14'd0;
            status_value_next  = 16'd0;
            length_value_next  = 32'd0;
            length_seen_next   = 1'b0;
            chunk_flag_next    = 1'b0;
            location_flag_next = 1'b0;
            tick_count_next    = 16'd0;
        end
        if (restart || line_start)
        begin
            line_length_next       = 8'd0;
            line_class_next        = CLS_UNDECIDED;
            number_phase_next      = (phase_next == PH_STATUS) ? NUM_FIND : NUM_WS;
            number_negative_next   = 1'b0;
            acc_next               = 33'd0;
            chunk_match_next       = 3'd0;
            location_nonempty_next = 1'b0;
            line_cut_next          = 1'b0;
        end
    end

    always_comb
    begin
        res.valid          = emit;
        res.out_kind       = emit_kind;
        res.location_byte  = emit_byte;
        res.status_code    = status_value_next;
        res.content_length = length_value_next;
        res.has_length     = length_seen_next;
        res.chunked_seen   = chunk_flag_next;
        res.has_location   = location_flag_next;
        res.verdict        = emit_verdict;
        res.error_code     = emit_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_STATUS;
            line_length_reg       <= 8'd0;
            header_total_reg      <= 14'd0;
            line_class_reg        <= CLS_UNDECIDED;
            number_phase_reg      <= NUM_FIND;
            number_negative_reg   <= 1'b0;
            status_value_reg      <= 16'd0;
            acc_reg               <= 33'd0;
            length_value_reg      <= 32'd0;
            length_seen_reg       <= 1'b0;
            chunk_match_reg       <= 3'd0;
            chunk_flag_reg        <= 1'b0;
            location_nonempty_reg <= 1'b0;
            location_flag_reg     <= 1'b0;
            line_cut_reg          <= 1'b0;
            tick_count_reg        <= 16'd0;
        end
        else
        begin
            phase_reg             <= phase_next;
            line_length_reg       <= line_length_next;
            header_total_reg      <= header_total_next;
            line_class_reg        <= line_class_next;
            number_phase_reg      <= number_phase_next;
            number_negative_reg   <= number_negative_next;
            status_value_reg      <= status_value_next;
            acc_reg               <= acc_next;
            length_value_reg      <= length_value_next;
            length_seen_reg       <= length_seen_next;
            chunk_match_reg       <= chunk_match_next;
            chunk_flag_reg        <= chunk_flag_next;
            location_nonempty_reg <= location_nonempty_next;
            location_flag_reg     <= location_flag_next;
            line_cut_reg          <= line_cut_next;
            tick_count_reg        <= tick_count_next;
        end
    end

endmodule
`default_nettype wire

FILE: bench/hrhp_checker.sv
// Checker for the HTTP reply header parser: watches the event, config and result channels,
// predicts every result and compares it field by field. Depends on hrhp_pkg.
`timescale 1ns / 1ps
module hrhp_checker
    import hrhp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_ready,
    input  wire logic [1:0]         kind,
    input  wire logic [7:0]         data_byte,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire logic [1:0]         out_kind,
    input  wire logic [7:0]         location_byte,
    input  wire logic signed [15:0] status_code,
    input  wire logic [31:0]        content_length,
    input  wire logic               has_length,
    input  wire logic               chunked_seen,
    input  wire logic               has_location,
    input  wire logic [2:0]         verdict,
    input  wire logic [2:0]         error_code,
    output int                      mism_count,
    output int                      due_count
);

    localparam logic [1:0] PH_STATUS  = 2'd0;
    localparam logic [1:0] PH_HEADERS = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    typedef struct packed {
        logic [1:0]  okind;
        logic [7:0]  lbyte;
        logic [15:0] status;
        logic [31:0] clen;
        logic        hlen;
        logic        chunked;
        logic        hloc;
        logic [2:0]  vd;
        logic [2:0]  ec;
    } reply_ev_t;

    reply_ev_t   reply_due_q[$];

    logic [7:0]  lim;
    logic [13:0] total_lim;
    logic [15:0] tick_lim;

    logic [1:0]  ph;
    logic [7:0]  len;
    logic [2:0]  cls;
    logic [2:0]  nph;
    logic        neg;
    logic [2:0]  chunk_m;
    logic [15:0] hdr_total;
    logic [15:0] status_val;
    logic [15:0] ticks;
    logic        chunk_fl;
    logic        loc_ne;
    logic        loc_fl;
    logic        cut;
    logic [32:0] acc;
    logic [31:0] len_val;
    logic        len_seen;

    function automatic logic [7:0] lc(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic [7:0] header_name_at(input logic [2:0] k, input logic [7:0] pos);
        string s;
        s = (k == CLS_NAME_LEN) ? "content-length:"
          : (k == CLS_NAME_ENC) ? "transfer-encoding:" : "location:";
        return (pos < s.len()) ? s[pos] : 8'h00;
    endfunction

    task automatic note(input string msg);
        mism_count++;
        if (mism_count <= 40)
        begin
            $display("ERROR %0t: %s", $time, msg);
        end
    endtask

    task automatic new_line();
        len     = 0;
        cls     = CLS_UNDECIDED;
        nph     = (ph == PH_STATUS) ? NUM_FIND : NUM_WS;
        neg     = 1'b0;
        acc     = '0;
        chunk_m = 0;
        loc_ne  = 1'b0;
        cut     = 1'b0;
    endtask

    task automatic new_reply();
        ph         = PH_STATUS;
        hdr_total  = 0;
        status_val = 0;
        len_val    = 0;
        len_seen   = 1'b0;
        chunk_fl   = 1'b0;
        loc_fl     = 1'b0;
        ticks      = 0;
        new_line();
    endtask

    task automatic put(input logic [1:0] k, input logic [7:0] b, input logic [2:0] v,
                       input logic [2:0] e);
        reply_ev_t r;
        r = '{k, b, status_val, len_val, len_seen, chunk_fl, loc_fl, v, e};
        reply_due_q.push_back(r);
    endtask

    task automatic abort(input logic [2:0] e);
        ph = PH_DONE;
        put(OUT_ERROR, 8'h00, VERDICT_OK, e);
    endtask

    task automatic digit_char(input logic [7:0] c);
        logic [36:0] p;
        if (nph == NUM_WS)
        begin
            if (blank_char(c))
            begin
                return;
            end
            if (c == "+" || c == "-")
            begin
                neg = (c == "-");
                nph = NUM_SIGN;
                return;
            end
            nph = NUM_SIGN;
        end
        if (nph == NUM_SIGN || nph == NUM_DIGITS)
        begin
            if (c >= "0" && c <= "9")
            begin
                p   = 37'(acc) * 37'd10 + 37'(c - "0");
                acc = (p > 37'(ACC_CAP)) ? ACC_CAP : p[32:0];
                nph = NUM_DIGITS;
            end
            else
            begin
                nph = NUM_END;
            end
        end
    endtask

    task automatic status_byte(input logic [7:0] c, input logic [7:0] pos);
        string pre;
        pre = "HTTP/";
        if (pos < 5 && c != pre[pos])
        begin
            cls = CLS_OTHER;
        end
        if (c == 8'h00)
        begin
            cut = 1'b1;
            if (nph != NUM_FIND)
            begin
                nph = NUM_END;
            end
            return;
        end
        if (nph == NUM_FIND)
        begin
            if (c == " ")
            begin
                nph = NUM_WS;
            end
        end
        else
        begin
            digit_char(c);
        end
    endtask

    task automatic header_byte(input logic [7:0] c, input logic [7:0] pos);
        logic [7:0] l;
        logic [7:0] last;
        logic       hit;
        string      word;
        word = "chunked";
        l    = lc(c);
        if (c == 8'h00)
        begin
            cut = 1'b1;
            if (cls < CLS_OTHER)
            begin
                cls = CLS_OTHER;
            end
            if (cls == CLS_LENGTH)
            begin
                nph = NUM_END;
            end
            return;
        end
        if (cls == CLS_UNDECIDED)
        begin
            cls = (l == "c") ? CLS_NAME_LEN : (l == "t") ? CLS_NAME_ENC
                : (l == "l") ? CLS_NAME_LOC : CLS_OTHER;
            return;
        end
        if (cls >= CLS_NAME_LEN && cls <= CLS_NAME_LOC)
        begin
            last = (cls == CLS_NAME_LEN) ? 8'd14 : (cls == CLS_NAME_ENC) ? 8'd17 : 8'd8;
            if (l != header_name_at(cls, pos))
            begin
                cls = CLS_OTHER;
            end
            else if (pos == last)
            begin
                cls = cls + 3'd4;
            end
            return;
        end
        if (cls == CLS_LENGTH)
        begin
            digit_char(c);
        end
        else if (cls == CLS_ENCODING)
        begin
            if (chunk_m < 7)
            begin
                hit = (chunk_m == 0) ? (c == "c" || c == "C") : (c == word[chunk_m]);
                if (hit)
                begin
                    chunk_m++;
                end
                else
                begin
                    chunk_m = (c == "c" || c == "C") ? 3'd1 : 3'd0;
                end
            end
        end
        else if (cls == CLS_LOCATION)
        begin
            if (!loc_ne && (c == " " || c == "\t"))
            begin
                return;
            end
            loc_ne = 1'b1;
            put(OUT_LOC_BYTE, c, VERDICT_OK, ERR_NONE);
        end
    endtask

    task automatic close_status(output logic [2:0] e);
        logic [32:0] m;
        e = ERR_NONE;
        if (len < 5 || cls == CLS_OTHER)
        begin
            e = ERR_NOT_HTTP;
            return;
        end
        if (nph == NUM_FIND)
        begin
            e = ERR_MALFORMED;
            return;
        end
        if (neg)
        begin
            m          = (acc > 33'd32768) ? 33'd32768 : acc;
            status_val = 16'(33'd0 - m);
        end
        else
        begin
            status_val = (acc > 33'd32767) ? 16'd32767 : acc[15:0];
        end
        ph = PH_HEADERS;
        new_line();
    endtask

    task automatic commit_line(output logic [2:0] e);
        int sum;
        e   = ERR_NONE;
        sum = hdr_total + len;
        if (sum > total_lim)
        begin
            e = ERR_TOO_LARGE;
            return;
        end
        hdr_total = 16'(sum);
        if (cls == CLS_LENGTH)
        begin
            if (acc > 33'hFFFF_FFFF)
            begin
                len_val = 32'hFFFF_FFFF;
            end
            else
            begin
                len_val = neg ? 32'd0 - acc[31:0] : acc[31:0];
            end
            len_seen = 1'b1;
        end
        else if (cls == CLS_ENCODING)
        begin
            if (chunk_m == 7)
            begin
                chunk_fl = 1'b1;
            end
        end
        else if (cls == CLS_LOCATION)
        begin
            loc_fl = loc_ne;
        end
    endtask

    task automatic give_verdict();
        logic signed [15:0] st;
        logic [2:0]         v;
        st = status_val;
        if (chunk_fl)
        begin
            v = VERDICT_CHUNKED;
        end
        else if (st == 301 || st == 302 || st == 303 || st == 307 || st == 308)
        begin
            v = loc_fl ? VERDICT_REDIRECT : VERDICT_NO_TARGET;
        end
        else if (st == 200)
        begin
            v = VERDICT_OK;
        end
        else
        begin
            v = VERDICT_OTHER;
        end
        ph = PH_DONE;
        put(OUT_DONE, 8'h00, v, ERR_NONE);
    endtask

    task automatic parse_event(input logic [1:0] k, input logic [7:0] c);
        logic [2:0]  e;
        logic [7:0]  pos;
        logic [16:0] n;
        if (k == KIND_RESTART)
        begin
            new_reply();
            return;
        end
        if (ph == PH_DONE)
        begin
            return;
        end
        if (k == KIND_TICK)
        begin
            n = {1'b0, ticks} + 17'd1;
            if (n > {1'b0, tick_lim})
            begin
                abort(ERR_TIMEOUT);
            end
            else
            begin
                ticks = n[15:0];
            end
            return;
        end
        if (k == KIND_CLOSE)
        begin
            if (len != 0)
            begin
                if (ph == PH_STATUS)
                begin
                    close_status(e);
                end
                else
                begin
                    commit_line(e);
                end
                if (e != ERR_NONE)
                begin
                    abort(e);
                    return;
                end
            end
            abort(ERR_CLOSED);
            return;
        end
        if (c == 8'h0D)
        begin
            return;
        end
        if (c == 8'h0A)
        begin
            if (ph == PH_STATUS)
            begin
                close_status(e);
                if (e != ERR_NONE)
                begin
                    abort(e);
                end
                return;
            end
            if (len == 0)
            begin
                give_verdict();
                return;
            end
            commit_line(e);
            if (e != ERR_NONE)
            begin
                abort(e);
                return;
            end
            if (cls == CLS_LOCATION)
            begin
                new_line();
                put(OUT_LOC_END, 8'h00, VERDICT_OK, ERR_NONE);
                return;
            end
            new_line();
            return;
        end
        if (len >= lim)
        begin
            return;
        end
        pos = len;
        len++;
        if (cut)
        begin
            return;
        end
        if (ph == PH_STATUS)
        begin
            status_byte(c, pos);
        end
        else
        begin
            header_byte(c, pos);
        end
    endtask

    task automatic compare_reply();
        reply_ev_t w;
        if (reply_due_q.size() == 0)
        begin
            note($sformatf("result with nothing expected, out_kind %0d", out_kind));
            return;
        end
        w = reply_due_q.pop_front();
        if (out_kind != w.okind)
            note($sformatf("out_kind got %0d want %0d", out_kind, w.okind));
        if (location_byte != w.lbyte)
            note($sformatf("location_byte got %0h want %0h", location_byte, w.lbyte));
        if (status_code != $signed(w.status))
            note($sformatf("status_code got %0d want %0d", status_code, $signed(w.status)));
        if (content_length != w.clen)
            note($sformatf("content_length got %0h want %0h", content_length, w.clen));
        if (has_length != w.hlen)
            note($sformatf("has_length got %0d want %0d", has_length, w.hlen));
        if (chunked_seen != w.chunked)
            note($sformatf("chunked_seen got %0d want %0d", chunked_seen, w.chunked));
        if (has_location != w.hloc)
            note($sformatf("has_location got %0d want %0d", has_location, w.hloc));
        if (verdict != w.vd)
            note($sformatf("verdict got %0d want %0d", verdict, w.vd));
        if (error_code != w.ec)
            note($sformatf("error_code got %0d want %0d", error_code, w.ec));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim        = LINE_LIMIT_RESET;
            total_lim  = TOTAL_LIMIT_RESET;
            tick_lim   = TIMEOUT_RESET;
            mism_count = 0;
            reply_due_q.delete();
            new_reply();
            due_count <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                compare_reply();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LINE_LIMIT:  lim = cfg_data[7:0];
                    REG_TOTAL_LIMIT: total_lim = cfg_data[13:0];
                    REG_TIMEOUT:     tick_lim = cfg_data;
                    default:         ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                parse_event(kind, data_byte);
            end
            due_count <= reply_due_q.size();
        end
    end

endmodule

FILE: bench/tb.sv
// Testbench top for http_reply_header_parser: drives replies, events and register writes
// with random gaps and stalls; hrhp_checker predicts and compares. Depends on hrhp_pkg.
`timescale 1ns / 1ps
module tb;
    import hrhp_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    logic [1:0]         kind = KIND_DATA;
    logic [7:0]         data_byte = 8'h00;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = REG_LINE_LIMIT;
    logic [15:0]        cfg_data = 16'h0000;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [1:0]         out_kind;
    logic [7:0]         location_byte;
    logic signed [15:0] status_code;
    logic [31:0]        content_length;
    logic               has_length;
    logic               chunked_seen;
    logic               has_location;
    logic [2:0]         verdict;
    logic [2:0]         error_code;
    int                 mism_count;
    int                 due_count;

    logic [9:0]         reply_ev_q[$];
    int                 sent_items = 0;
    logic               send_calm = 1'b0;

    http_reply_header_parser dut (.*);
    hrhp_checker chk (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int stall;
        int served;
        served = 0;
        forever
        begin
            if (served % 40 == 0)
                stall = $urandom_range(0, 2);
            stall = (stall == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
            served++;
        end
    end

    task automatic send_item(input logic [1:0] k, input logic [7:0] b);
        int gap;
        if (sent_items % 50 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        data_byte  <= b;
        do @(posedge clk); while (!item_ready);
        sent_items++;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        do @(posedge clk); while (due_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_text(input string s, input bit mutate);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mutate && $urandom_range(0, 79) == 0)
                c = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            reply_ev_q.push_back({KIND_DATA, c});
        end
    endtask

    function automatic string mix_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if (r[i] >= "a" && r[i] <= "z")
                    r[i] = r[i] - 8'd32;
                else if (r[i] >= "A" && r[i] <= "Z")
                    r[i] = r[i] + 8'd32;
            end
        end
        return r;
    endfunction

    task automatic flush_reply();
        logic [9:0] ev;
        while (reply_ev_q.size() != 0)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(KIND_TICK, 8'($urandom));
            ev = reply_ev_q.pop_front();
            send_item(ev[9:8], ev[7:0]);
        end
    endtask

    task automatic directed(input string s, input logic [1:0] tail);
        reply_ev_q.push_back({KIND_RESTART, 8'h00});
        push_text(s, 1'b0);
        if (tail != KIND_DATA)
            reply_ev_q.push_back({tail, 8'h00});
        while (reply_ev_q.size() != 0)
        begin
            logic [9:0] ev;
            ev = reply_ev_q.pop_front();
            send_item(ev[9:8], ev[7:0]);
        end
    endtask

    task automatic random_reply();
        string st;
        string eol;
        int    nh;
        eol = ($urandom_range(0, 1) == 0) ? "\r\n" : "\n";
        reply_ev_q.push_back({KIND_RESTART, 8'h00});
        case ($urandom_range(0, 13))
            0:  st = "200";
            1:  st = "301";
            2:  st = "302";
            3:  st = "303";
            4:  st = "307";
            5:  st = "308";
            6:  st = "-5";
            7:  st = "+200";
            8:  st = "99999999999";
            9:  st = " \t 404 OK";
            10: st = "-40000";
            11: st = "abc";
            default: st = $sformatf("%0d", $urandom_range(0, 999));
        endcase
        case ($urandom_range(0, 15))
            0:       st = "FTP/1.0 200";
            1:       st = "HTTP/1.1";
            2:       st = "HTT";
            default: st = {mix_case("HTTP/1.1 ") == "" ? "" : "HTTP/1.1 ", st};
        endcase
        push_text({st, eol}, 1'b1);
        nh = $urandom_range(0, 4);
        for (int h = 0; h < nh; h++)
        begin
            case ($urandom_range(0, 5))
                0: push_text({mix_case("Content-Length:"), " ",
                              $sformatf("%0d", $urandom), eol}, 1'b1);
                1: push_text({mix_case("Content-Length:"),
                              ($urandom_range(0, 1) ? " -12" : "99999999999"), eol}, 1'b1);
                2: push_text({mix_case("Transfer-Encoding:"),
                              ($urandom_range(0, 1) ? " gzip, chunked" : " Chunkex"), eol},
                             1'b1);
                3: push_text({mix_case("Location:"), " /p", $sformatf("%0d", $urandom % 999),
                              eol}, 1'b1);
                4: push_text({mix_case("Location:"), ($urandom_range(0, 1) ? " \t" : ""),
                              eol}, 1'b1);
                default: push_text({"X-Tag: v", eol}, 1'b1);
            endcase
        end
        case ($urandom_range(0, 9))
            0: reply_ev_q.push_back({KIND_CLOSE, 8'h00});
            1:
            begin
                push_text(mix_case("Location: /half"), 1'b0);
                reply_ev_q.push_back({KIND_CLOSE, 8'h00});
            end
            2: reply_ev_q.push_back({KIND_DATA, 8'($urandom_range(0, 255))});
            default: push_text(eol, 1'b0);
        endcase
        flush_reply();
    endtask

    initial
    begin
        int goal;
        logic [15:0] set_lim [7];
        logic [15:0] set_tot [7];
        logic [15:0] set_to  [7];
        set_lim = '{255, 1, 12, 255, 40, 255, 7};
        set_tot = '{8192, 0, 16383, 60, 200, 16383, 100};
        set_to  = '{20000, 1, 65535, 30, 5, 65535, 3};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed("HTTP/1.1 200 OK\r\nContent-Length: 42\r\n\r\n", KIND_DATA);
        directed("HTTP/1.1 301 Moved\r\nLocation: /x\r\n\r\n", KIND_DATA);
        directed("HTTP/1.1 302\r\nLocation:  \r\n\r\n", KIND_DATA);
        directed("HTTP/1.0 200\r\ntransfer-ENCODING: Chunked\r\n\n", KIND_DATA);
        directed("HTTP/1.1 99999\r\nCONTENT-LENGTH: 99999999999\r\n\r\n", KIND_DATA);
        directed("HTTP/1.1 -99999\nContent-Length: -5\n\n", KIND_DATA);
        reply_ev_q.push_back({KIND_RESTART, 8'h00});
        push_text("HTTP/1.1 404\nLocation: /a", 1'b0);
        reply_ev_q.push_back({KIND_DATA, 8'h00});
        push_text("bc\n\n", 1'b0);
        flush_reply();
        directed("HTTP/1.1\n", KIND_DATA);
        directed("FTP 200\n", KIND_DATA);
        directed("HTTP/1.1 307\nLocation: /p", KIND_CLOSE);
        directed("HTTP/1.1 200", KIND_CLOSE);
        directed("HTTP/1.1 200\n", KIND_TICK);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_CLOSE, 8'h00);

        for (int p = 0; p < 7; p++)
        begin
            write_reg(REG_LINE_LIMIT, set_lim[p]);
            write_reg(REG_TOTAL_LIMIT, set_tot[p]);
            write_reg(REG_TIMEOUT, set_to[p]);
            goal = 1700 * (p + 1) / 7 + 60;
            while (sent_items < goal)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom));
                else
                    random_reply();
            end
        end

        settle();
        if (mism_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
